/* rtl/sobcd_pkg.sv */
// Types and constants shared by the command decoder files.
`timescale 1ns / 1ps
`default_nettype none
package sobcd_pkg;

  typedef enum logic [4:0] {
    MODE_INACTIVE = 5'b00001,
    MODE_COMMAND  = 5'b00010,
    MODE_DATA     = 5'b00100,
    MODE_CHECK    = 5'b01000,
    MODE_FAULTED  = 5'b10000
  } mode_t;

  typedef logic [6:0][2:0] param_tbl_t;

  // entry 0 is parameter code 1 (slew) ... entry 6 is code 7 (baud rate)
  localparam param_tbl_t PARAM_DEFAULTS = {3'd0, 3'd5, 3'd5, 3'd0, 3'd4, 3'd4, 3'd0};

  localparam logic [7:0] RESET_MASK       = 8'hE3;
  localparam logic [7:0] RESET_PATTERN    = 8'hC1;
  localparam logic [7:0] BYTE_DATA_SWITCH = 8'hE1;
  localparam logic [7:0] BYTE_ESCAPE      = 8'hE3;
  localparam logic [7:0] BYTE_RESET_REPLY = 8'hCD;
  localparam logic [7:0] BYTE_UNDEF_READ  = 8'hFE;
  localparam logic [7:0] MASK_READ_HI     = 8'hF0;
  localparam logic [7:0] MASK_WRITE       = 8'hFE;
  localparam logic [7:0] MASK_SINGLE_BIT  = 8'hFC;

  localparam logic [2:0] OP_SINGLE_BIT = 3'b100;
  localparam logic [2:0] OP_SEARCH     = 3'b101;
  localparam logic [2:0] OP_BUS_RESET  = 3'b110;

  localparam logic [2:0] PARAM_READ = 3'd0;
  localparam logic [2:0] PARAM_BAUD = 3'd7;
  localparam logic [2:0] BAUD_MAX   = 3'd3;

  localparam logic [1:0] SPEED_REGULAR = 2'd0;
  localparam logic [1:0] SPEED_INVALID = 2'd3;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       protocol_error;
    logic [1:0] bus_speed;
  } result_t;

  typedef struct packed {
    mode_t      mode_next;
    logic       tbl_we;
    logic [2:0] tbl_idx;
    logic [2:0] tbl_val;
    logic       speed_we;
    logic [1:0] speed_val;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       protocol_error;
  } dec_t;

endpackage
`default_nettype wire

/* rtl/sobcd_rx_if.sv */
// Host byte channel.
`timescale 1ns / 1ps
`default_nettype none
interface sobcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

/* rtl/sobcd_tx_if.sv */
// Result channel.
`timescale 1ns / 1ps
`default_nettype none
interface sobcd_tx_if;
  logic       valid;
  logic       ready;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       protocol_error;
  logic [1:0] bus_speed;

  modport source (output valid, output reply_valid, output reply_byte,
                  output protocol_error, output bus_speed, input ready);
  modport sink (input valid, input reply_valid, input reply_byte,
                input protocol_error, input bus_speed, output ready);
endinterface
`default_nettype wire

/* rtl/sobcd_decode.sv */
// Combinational decode of one host byte against the current mode and parameters.
`timescale 1ns / 1ps
`default_nettype none
module sobcd_decode (
  input  wire logic [7:0]           rx_byte,
  input  sobcd_pkg::mode_t          mode,
  input  sobcd_pkg::param_tbl_t     tbl,
  output sobcd_pkg::dec_t           dec
);

  logic       run_cmd;
  logic [2:0] code;
  logic [2:0] val;
  logic [2:0] op;
  logic [2:0] rd_idx;
  logic [1:0] sp;

  assign code   = rx_byte[6:4];
  assign val    = rx_byte[3:1];
  assign op     = rx_byte[7:5];
  assign rd_idx = val - 3'd1;
  assign sp     = rx_byte[3:2];

  always_comb begin
    dec             = '0;
    dec.mode_next   = mode;
    dec.tbl_idx     = code - 3'd1;
    dec.tbl_val     = val;
    dec.speed_val   = (sp == sobcd_pkg::SPEED_INVALID) ? sobcd_pkg::SPEED_REGULAR : sp;
    run_cmd         = 1'b0;

    case (mode)
      sobcd_pkg::MODE_INACTIVE: begin
        if ((rx_byte & sobcd_pkg::RESET_MASK) == sobcd_pkg::RESET_PATTERN) begin
          dec.mode_next = sobcd_pkg::MODE_COMMAND;
        end
      end
      sobcd_pkg::MODE_COMMAND: run_cmd = 1'b1;
      sobcd_pkg::MODE_DATA: begin
        if (rx_byte == sobcd_pkg::BYTE_ESCAPE) begin
          dec.mode_next = sobcd_pkg::MODE_CHECK;
        end
      end
      sobcd_pkg::MODE_CHECK: begin
        if (rx_byte == sobcd_pkg::BYTE_ESCAPE) begin
          dec.mode_next = sobcd_pkg::MODE_DATA;
        end else begin
          dec.mode_next = sobcd_pkg::MODE_COMMAND;
          run_cmd       = 1'b1;
        end
      end
      default: dec.mode_next = sobcd_pkg::MODE_FAULTED;
    endcase

    if (run_cmd) begin
      if (!rx_byte[0]) begin
        dec.protocol_error = 1'b1;
        dec.mode_next      = sobcd_pkg::MODE_FAULTED;
      end else if (rx_byte == sobcd_pkg::BYTE_DATA_SWITCH) begin
        dec.mode_next = sobcd_pkg::MODE_DATA;
      end else if (!rx_byte[7]) begin
        dec.reply_valid = 1'b1;
        if (code == sobcd_pkg::PARAM_READ) begin
          if (val == 3'd0) begin
            dec.reply_byte = sobcd_pkg::BYTE_UNDEF_READ;
          end else begin
            dec.reply_byte = (rx_byte & sobcd_pkg::MASK_READ_HI) | {4'd0, tbl[rd_idx], 1'b0};
          end
        end else begin
          dec.tbl_we     = (code != sobcd_pkg::PARAM_BAUD) || (val <= sobcd_pkg::BAUD_MAX);
          dec.reply_byte = rx_byte & sobcd_pkg::MASK_WRITE;
        end
      end else begin
        case (op)
          sobcd_pkg::OP_SINGLE_BIT: begin
            dec.reply_valid = 1'b1;
            dec.reply_byte  = rx_byte & sobcd_pkg::MASK_SINGLE_BIT;
          end
          sobcd_pkg::OP_SEARCH: ;
          sobcd_pkg::OP_BUS_RESET: begin
            dec.speed_we    = 1'b1;
            dec.mode_next   = sobcd_pkg::MODE_COMMAND;
            dec.reply_valid = 1'b1;
            dec.reply_byte  = sobcd_pkg::BYTE_RESET_REPLY;
          end
          default: begin
            dec.protocol_error = 1'b1;
            dec.mode_next      = sobcd_pkg::MODE_FAULTED;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/serial_onewire_bridge_command_decoder.sv */
// Top level of the host command decoder for a serial to one-wire bridge.
// Every accepted host byte yields exactly one result transaction, in order: reply flag and
// byte, protocol error flag and the bus speed after that byte. Bytes are registered on entry,
// then decoded and applied to the mode, parameter and speed registers, and the result lands
// in an output register, so one byte per cycle is sustained while the output is taken; the
// mode loop closes through the mode register alone.
// Input is held off only while both registers are full and the output is not being taken.
// A protocol error leaves the block faulted, ignoring every byte silently, until reset.
`timescale 1ns / 1ps
`default_nettype none
module serial_onewire_bridge_command_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  sobcd_rx_if.sink    rx,
  sobcd_tx_if.source  tx
);

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  out_valid;
  sobcd_pkg::result_t    out_res;
  sobcd_pkg::mode_t      mode;
  sobcd_pkg::param_tbl_t tbl;
  logic [1:0]            speed;
  sobcd_pkg::dec_t       dec;
  logic                  advance;
  logic [1:0]            speed_next;

  sobcd_decode u_decode (
    .rx_byte (s1_byte),
    .mode    (mode),
    .tbl     (tbl),
    .dec     (dec)
  );

  assign advance    = s1_valid && (!out_valid || tx.ready);
  assign rx.ready   = !s1_valid || advance;
  assign speed_next = dec.speed_we ? dec.speed_val : speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= sobcd_pkg::MODE_INACTIVE;
      tbl   <= sobcd_pkg::PARAM_DEFAULTS;
      speed <= sobcd_pkg::SPEED_REGULAR;
    end else if (advance) begin
      mode  <= dec.mode_next;
      speed <= speed_next;
      if (dec.tbl_we) begin
        tbl[dec.tbl_idx] <= dec.tbl_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res.reply_valid    <= dec.reply_valid;
      out_res.reply_byte     <= dec.reply_byte;
      out_res.protocol_error <= dec.protocol_error;
      out_res.bus_speed      <= speed_next;
    end
  end

  assign tx.valid          = out_valid;
  assign tx.reply_valid    = out_res.reply_valid;
  assign tx.reply_byte     = out_res.reply_byte;
  assign tx.protocol_error = out_res.protocol_error;
  assign tx.bus_speed      = out_res.bus_speed;

  a_error_faults: assert property (@(posedge clk) disable iff (rst)
    advance && dec.protocol_error |=> mode == sobcd_pkg::MODE_FAULTED)
    else $error("protocol error did not fault the decoder");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == sobcd_pkg::MODE_FAULTED |=> mode == sobcd_pkg::MODE_FAULTED)
    else $error("faulted mode left without reset");

  a_no_reply_zero: assert property (@(posedge clk) disable iff (rst)
    tx.valid && !tx.reply_valid |-> tx.reply_byte == 8'd0)
    else $error("reply byte not cleared without reply");

  a_err_no_reply: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.protocol_error |-> !tx.reply_valid)
    else $error("reply sent with protocol error");

  a_speed_legal: assert property (@(posedge clk) disable iff (rst)
    advance |=> speed != sobcd_pkg::SPEED_INVALID)
    else $error("illegal bus speed stored");

endmodule
`default_nettype wire

/* test/serial_onewire_bridge_command_decoder_test.sv */
// Self-checking testbench for the host command decoder, with a scoreboard and random handshakes.
`timescale 1ns / 1ps
module serial_onewire_bridge_command_decoder_test;

  localparam logic [2:0] OP_PULSE = 3'b111;
  localparam int RANDOM_ITEMS = 1020;
  localparam int QUIET_TAIL = 150;
  localparam int HOLD_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] DIRECTED [27] = '{
    8'h00, 8'hFF, 8'hC3, 8'hE1, 8'hDD, 8'h01, 8'h0F, 8'h7F, 8'h77,
    8'h0F, 8'h1F, 8'h03, 8'h81, 8'h9F, 8'hA1, 8'hBF, 8'hC5, 8'hC9,
    8'hCD, 8'hC1, 8'hE1, 8'h00, 8'hFF, 8'hE3, 8'hE3, 8'hE3, 8'hC9
  };

  class reply_scoreboard;
    sobcd_pkg::mode_t      host_mode;
    sobcd_pkg::param_tbl_t par_codes;
    logic [1:0]            speed;
    sobcd_pkg::result_t    pending_replies[$];
    int                    failures;

    function new();
      host_mode = sobcd_pkg::MODE_INACTIVE;
      par_codes = sobcd_pkg::PARAM_DEFAULTS;
      speed = sobcd_pkg::SPEED_REGULAR;
      failures = 0;
    endfunction

    function void run_command(logic [7:0] b, inout sobcd_pkg::result_t r);
      logic [2:0] code;
      logic [2:0] val;
      code = b[6:4];
      val = b[3:1];
      if (!b[0]) begin
        r.protocol_error = 1'b1;
        host_mode = sobcd_pkg::MODE_FAULTED;
      end else if (b == sobcd_pkg::BYTE_DATA_SWITCH) begin
        host_mode = sobcd_pkg::MODE_DATA;
      end else if (!b[7]) begin
        r.reply_valid = 1'b1;
        if (code == sobcd_pkg::PARAM_READ) begin
          if (val == 3'd0) r.reply_byte = sobcd_pkg::BYTE_UNDEF_READ;
          else r.reply_byte = (b & sobcd_pkg::MASK_READ_HI) |
                              {4'b0, par_codes[val - 3'd1], 1'b0};
        end else begin
          // baud rate codes above the maximum are dropped silently
          if (code != sobcd_pkg::PARAM_BAUD || val <= sobcd_pkg::BAUD_MAX)
            par_codes[code - 3'd1] = val;
          r.reply_byte = b & sobcd_pkg::MASK_WRITE;
        end
      end else begin
        case (b[7:5])
          sobcd_pkg::OP_SINGLE_BIT: begin
            r.reply_valid = 1'b1;
            r.reply_byte = b & sobcd_pkg::MASK_SINGLE_BIT;
          end
          sobcd_pkg::OP_SEARCH: ;
          sobcd_pkg::OP_BUS_RESET: begin
            speed = (b[3:2] == sobcd_pkg::SPEED_INVALID) ? sobcd_pkg::SPEED_REGULAR : b[3:2];
            host_mode = sobcd_pkg::MODE_COMMAND;
            r.reply_valid = 1'b1;
            r.reply_byte = sobcd_pkg::BYTE_RESET_REPLY;
          end
          default: begin
            r.protocol_error = 1'b1;
            host_mode = sobcd_pkg::MODE_FAULTED;
          end
        endcase
      end
    endfunction

    function void note_input(logic [7:0] b);
      sobcd_pkg::result_t r;
      r = '0;
      case (host_mode)
        sobcd_pkg::MODE_INACTIVE: begin
          if ((b & sobcd_pkg::RESET_MASK) == sobcd_pkg::RESET_PATTERN)
            host_mode = sobcd_pkg::MODE_COMMAND;
        end
        sobcd_pkg::MODE_COMMAND: run_command(b, r);
        sobcd_pkg::MODE_DATA: begin
          if (b == sobcd_pkg::BYTE_ESCAPE) host_mode = sobcd_pkg::MODE_CHECK;
        end
        sobcd_pkg::MODE_CHECK: begin
          if (b == sobcd_pkg::BYTE_ESCAPE) begin
            host_mode = sobcd_pkg::MODE_DATA;
          end else begin
            host_mode = sobcd_pkg::MODE_COMMAND;
            run_command(b, r);
          end
        end
        default: host_mode = sobcd_pkg::MODE_FAULTED;
      endcase
      r.bus_speed = speed;
      pending_replies.push_back(r);
    endfunction

    function void check_result(sobcd_pkg::result_t got);
      sobcd_pkg::result_t want;
      if (pending_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected transaction: valid=%0b byte=%02h err=%0b speed=%0d",
                   got.reply_valid, got.reply_byte, got.protocol_error, got.bus_speed);
        return;
      end
      want = pending_replies.pop_front();
      if (got.reply_valid !== want.reply_valid || got.reply_byte !== want.reply_byte ||
          got.protocol_error !== want.protocol_error || got.bus_speed !== want.bus_speed) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: expected valid=%0b byte=%02h err=%0b speed=%0d, ",
                    "got valid=%0b byte=%02h err=%0b speed=%0d"},
                   want.reply_valid, want.reply_byte, want.protocol_error, want.bus_speed,
                   got.reply_valid, got.reply_byte, got.protocol_error, got.bus_speed);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic gaps_on;
  logic hold_req;
  int   hold_left;
  int   stall_left;
  int   cycles;
  int   items_sent;
  int   next_hold;

  reply_scoreboard sb = new();

  sobcd_rx_if rx_ch ();
  sobcd_tx_if tx_ch ();

  serial_onewire_bridge_command_decoder uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rx_ch.valid && rx_ch.ready) sb.note_input(rx_ch.rx_byte);
    if (!rst && tx_ch.valid && tx_ch.ready)
      sb.check_result({tx_ch.reply_valid, tx_ch.reply_byte, tx_ch.protocol_error,
                       tx_ch.bus_speed});
  end

  // result side: long hold on request, otherwise short random stalls
  always @(negedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      tx_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      tx_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      tx_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      tx_ch.ready <= 1'b0;
    end else begin
      tx_ch.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    items_sent++;
  endtask

  // odd command byte that keeps the decoder in command mode
  function automatic logic [7:0] pick_command();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 3) == 0) b[7:4] = 4'h0;
    b[0] = 1'b1;
    if (b[7:5] == OP_PULSE) b[$urandom_range(5, 6)] = 1'b0;
    return b;
  endfunction

  task automatic data_session();
    int n;
    logic [7:0] d;
    bit staying;
    send_byte(sobcd_pkg::BYTE_DATA_SWITCH);
    staying = 1'b1;
    while (staying) begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        d = 8'($urandom);
        if (d == sobcd_pkg::BYTE_ESCAPE) d = d ^ 8'h04;
        send_byte(d);
      end
      send_byte(sobcd_pkg::BYTE_ESCAPE);
      case ($urandom_range(0, 3))
        0: send_byte(sobcd_pkg::BYTE_ESCAPE);
        1: send_byte(sobcd_pkg::BYTE_DATA_SWITCH);
        default: begin
          send_byte(pick_command());
          staying = 1'b0;
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] fault_byte;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    tx_ch.ready = 1'b0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    cycles = 0;
    items_sent = 0;
    next_hold = 300;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      if (gaps_on && items_sent >= next_hold) begin
        hold_req = 1'b1;
        next_hold += 350;
      end
      if ($urandom_range(0, 9) < 7) send_byte(pick_command());
      else data_session();
    end

    // fault last: it sticks until reset
    if ($urandom_range(0, 1) == 0) fault_byte = 8'($urandom) & 8'hFE;
    else fault_byte = {OP_PULSE, 4'($urandom), 1'b1};
    if (fault_byte == sobcd_pkg::BYTE_DATA_SWITCH) fault_byte = sobcd_pkg::BYTE_ESCAPE;
    send_byte(fault_byte);
    send_byte(sobcd_pkg::RESET_PATTERN);
    repeat (5) send_byte(8'($urandom));
    @(negedge clk);
    rx_ch.valid <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
